/* hdl/hbmt_pkg.sv */
// Shared types and constants for the heartbeat membership table.
// No dependencies; used by every module in hdl/.
`default_nettype none
package hbmt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int SIDX_W      = 5;
	localparam int CFG_W       = 2;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_MERGE = 2'd1;
	localparam logic [1:0] OP_PING  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_ADDED   = 3'd1;
	localparam logic [2:0] EV_UPDATED = 3'd2;
	localparam logic [2:0] EV_REMOVED = 3'd3;
	localparam logic [2:0] EV_FULL    = 3'd4;
	localparam logic [2:0] EV_READ    = 3'd5;
	localparam logic [2:0] EV_DONE    = 3'd6;

	localparam logic [CFG_W-1:0] CFG_FAIL_TO   = 2'd0;
	localparam logic [CFG_W-1:0] CFG_REMOVE_TO = 2'd1;
	localparam logic [CFG_W-1:0] CFG_OWN_ID    = 2'd2;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] port;
		logic [31:0] heartbeat;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic failed;
		logic expired;
	} age_flags_t;

endpackage
`default_nettype wire

/* hdl/hbmt_mem.sv */
// Entry storage: one write port, one registered read port.
// Depends on hbmt_pkg (entry_t, TABLE_DEPTH, ADDR_W).
`default_nettype none
module hbmt_mem (
	input  wire logic                       clk,
	input  wire logic                       rd_en,
	input  wire logic [hbmt_pkg::ADDR_W-1:0] rd_addr,
	output hbmt_pkg::entry_t                rd_data,
	input  wire logic                       wr_en,
	input  wire logic [hbmt_pkg::ADDR_W-1:0] wr_addr,
	input  wire hbmt_pkg::entry_t           wr_data
);

	hbmt_pkg::entry_t mem_q [hbmt_pkg::TABLE_DEPTH];
	hbmt_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

/* hdl/hbmt_age.sv */
// Shared age unit: one 32-bit subtract, compared against both timeouts.
// Depends on hbmt_pkg (age_flags_t).
`default_nettype none
module hbmt_age (
	input  wire logic [31:0]    now,
	input  wire logic [31:0]    stamp,
	input  wire logic [15:0]    fail_to,
	input  wire logic [15:0]    remove_to,
	output hbmt_pkg::age_flags_t flags
);

	logic [31:0] age;

	assign age           = now - stamp;
	assign flags.failed  = age >= {16'd0, fail_to};
	assign flags.expired = age >= {16'd0, remove_to};

endmodule
`default_nettype wire

/* hdl/heartbeat_membership_table_top.sv */
// Heartbeat membership table top: sequencer, valid bits, config and result register.
// Depends on hbmt_pkg, hbmt_mem, hbmt_age.
//
// Merge, ping and tick scan the table one slot per cycle, while the result side
// does not stall, through the single read port of the entry memory; the shared
// age unit evaluates each slot on the registered read data. A merge or ping
// ends its scan early when it hits. A read looks up a single slot. New items
// are taken only while the sequencer is idle; the result register lets the
// next item start while the last result waits.
// No clearing pass: the valid bits reset at once.
`default_nettype none
module heartbeat_membership_table_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [hbmt_pkg::CFG_W-1:0]      cfg_index,
	input  wire logic [15:0]                     cfg_data,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire logic [1:0]                      operation,
	input  wire logic [31:0]                     current_time,
	input  wire logic [15:0]                     member_id,
	input  wire logic [15:0]                     member_port,
	input  wire logic [31:0]                     member_heartbeat,
	input  wire logic [hbmt_pkg::SIDX_W-1:0]     slot_index,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output logic [2:0]                           event_res,
	output logic [15:0]                          entry_id,
	output logic [15:0]                          entry_port,
	output logic [31:0]                          entry_heartbeat,
	output logic                                 entry_valid,
	output logic                                 entry_failed,
	output logic                                 last
);

	localparam int AW = hbmt_pkg::ADDR_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(hbmt_pkg::TABLE_DEPTH - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q, state_d;

	logic [15:0] fail_to_q, remove_to_q, own_id_q;

	logic [1:0]                  op_q;
	logic [31:0]                 now_q;
	logic [15:0]                 mid_q, mport_q;
	logic [31:0]                 mhb_q;
	logic [hbmt_pkg::SIDX_W-1:0] sidx_q;

	logic [hbmt_pkg::TABLE_DEPTH-1:0] valid_q;
	logic [AW-1:0] addr_q, ev_addr_s1, free_addr_q, rd_addr;
	logic          iss_q, pend_s1, free_q;

	logic rsp_valid_q;
	logic [2:0]  o_ev_q;
	logic [15:0] o_id_q, o_port_q;
	logic [31:0] o_hb_q;
	logic        o_vld_q, o_fail_q, o_last_q;

	logic acc, adv, rd_en, v, fail_zero, sidx_ok;
	hbmt_pkg::entry_t     rd_data, wd;
	hbmt_pkg::age_flags_t ag;

	logic          emit, we, clr, set_v, rec_free;
	logic [AW-1:0] wa;
	logic [2:0]    e_ev;
	logic [15:0]   e_id, e_port;
	logic [31:0]   e_hb;
	logic          e_vld, e_fail, e_last;

	assign req_stall = state_q != ST_IDLE;
	assign acc       = req_valid && !req_stall;
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign rd_addr   = (op_q == hbmt_pkg::OP_READ) ? AW'(sidx_q) : addr_q;
	assign rd_en     = (state_q == ST_SCAN) && adv && iss_q;
	assign v         = valid_q[ev_addr_s1];
	assign fail_zero = fail_to_q == 16'd0;
	assign sidx_ok   = int'(sidx_q) < hbmt_pkg::TABLE_DEPTH;

	hbmt_mem u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (we),
		.wr_addr (wa),
		.wr_data (wd)
	);

	hbmt_age u_age (
		.now       (now_q),
		.stamp     (rd_data.stamp),
		.fail_to   (fail_to_q),
		.remove_to (remove_to_q),
		.flags     (ag)
	);

	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		we       = 1'b0;
		wa       = ev_addr_s1;
		wd       = rd_data;
		clr      = 1'b0;
		set_v    = 1'b0;
		rec_free = 1'b0;
		e_ev     = hbmt_pkg::EV_NONE;
		e_id     = '0;
		e_port   = '0;
		e_hb     = '0;
		e_vld    = 1'b0;
		e_fail   = 1'b0;
		e_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (adv && pend_s1) begin
					unique case (op_q)
						hbmt_pkg::OP_TICK: begin
							if (v && ag.expired) begin
								emit   = 1'b1;
								clr    = 1'b1;
								e_ev   = hbmt_pkg::EV_REMOVED;
								e_id   = rd_data.id;
								e_port = rd_data.port;
								e_hb   = rd_data.heartbeat;
								e_fail = ag.failed;
								e_last = 1'b0;
							end
						end
						hbmt_pkg::OP_MERGE: begin
							if (v && rd_data.id == mid_q) begin
								emit    = 1'b1;
								state_d = ST_IDLE;
								e_id    = rd_data.id;
								e_port  = rd_data.port;
								e_vld   = 1'b1;
								if (!ag.failed && mhb_q > rd_data.heartbeat) begin
									we           = 1'b1;
									wd.heartbeat = mhb_q;
									wd.stamp     = now_q;
									e_ev         = hbmt_pkg::EV_UPDATED;
									e_hb         = mhb_q;
									e_fail       = fail_zero;
								end else begin
									e_hb   = rd_data.heartbeat;
									e_fail = ag.failed;
								end
							end else if (!v && !free_q) begin
								rec_free = 1'b1;
							end
						end
						hbmt_pkg::OP_PING: begin
							if (v && rd_data.id == own_id_q) begin
								emit         = 1'b1;
								state_d      = ST_IDLE;
								we           = 1'b1;
								wd.heartbeat = rd_data.heartbeat + 32'd1;
								wd.stamp     = now_q;
								e_ev         = hbmt_pkg::EV_UPDATED;
								e_id         = rd_data.id;
								e_port       = rd_data.port;
								e_hb         = rd_data.heartbeat + 32'd1;
								e_vld        = 1'b1;
								e_fail       = fail_zero;
							end
						end
						hbmt_pkg::OP_READ: begin
							emit    = 1'b1;
							state_d = ST_IDLE;
							e_ev    = hbmt_pkg::EV_READ;
							if (sidx_ok && v) begin
								e_id   = rd_data.id;
								e_port = rd_data.port;
								e_hb   = rd_data.heartbeat;
								e_vld  = 1'b1;
								e_fail = ag.failed;
							end
						end
						default: ;
					endcase
					if (state_d == ST_SCAN && ev_addr_s1 == LAST_ADDR) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				if (adv) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					unique case (op_q)
						hbmt_pkg::OP_MERGE: begin
							e_id   = mid_q;
							e_port = mport_q;
							e_hb   = mhb_q;
							if (free_q) begin
								we     = 1'b1;
								wa     = free_addr_q;
								wd     = '{id: mid_q, port: mport_q, heartbeat: mhb_q,
									stamp: now_q};
								set_v  = 1'b1;
								e_ev   = hbmt_pkg::EV_ADDED;
								e_vld  = 1'b1;
								e_fail = fail_zero;
							end else begin
								e_ev = hbmt_pkg::EV_FULL;
							end
						end
						hbmt_pkg::OP_PING: begin
							e_ev = hbmt_pkg::EV_NONE;
							e_id = own_id_q;
						end
						default: begin
							e_ev = hbmt_pkg::EV_DONE;
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fail_to_q   <= 16'd5;
			remove_to_q <= 16'd20;
			own_id_q    <= 16'd1;
			valid_q     <= '0;
			iss_q       <= 1'b0;
			pend_s1     <= 1'b0;
			free_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					hbmt_pkg::CFG_FAIL_TO:   fail_to_q   <= cfg_data;
					hbmt_pkg::CFG_REMOVE_TO: remove_to_q <= cfg_data;
					hbmt_pkg::CFG_OWN_ID:    own_id_q    <= cfg_data;
					default: ;
				endcase
			end
			if (clr) begin
				valid_q[ev_addr_s1] <= 1'b0;
			end
			if (set_v) begin
				valid_q[free_addr_q] <= 1'b1;
			end
			if (acc) begin
				iss_q   <= 1'b1;
				pend_s1 <= 1'b0;
				free_q  <= 1'b0;
			end else if (state_q == ST_SCAN && adv) begin
				pend_s1 <= iss_q;
				if (iss_q && (op_q == hbmt_pkg::OP_READ || addr_q == LAST_ADDR)) begin
					iss_q <= 1'b0;
				end
				if (rec_free) begin
					free_q <= 1'b1;
				end
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q    <= operation;
			now_q   <= current_time;
			mid_q   <= member_id;
			mport_q <= member_port;
			mhb_q   <= member_heartbeat;
			sidx_q  <= slot_index;
			addr_q  <= '0;
		end else if (rd_en) begin
			ev_addr_s1 <= rd_addr;
			addr_q     <= addr_q + AW'(1);
		end
		if (rec_free) begin
			free_addr_q <= ev_addr_s1;
		end
		if (emit) begin
			o_ev_q   <= e_ev;
			o_id_q   <= e_id;
			o_port_q <= e_port;
			o_hb_q   <= e_hb;
			o_vld_q  <= e_vld;
			o_fail_q <= e_fail;
			o_last_q <= e_last;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign event_res       = o_ev_q;
	assign entry_id        = o_id_q;
	assign entry_port      = o_port_q;
	assign entry_heartbeat = o_hb_q;
	assign entry_valid     = o_vld_q;
	assign entry_failed    = o_fail_q;
	assign last            = o_last_q;

	a_tick_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && op_q == hbmt_pkg::OP_TICK
		|=> $countones(valid_q) <= $past($countones(valid_q)))
		else $error("tick sweep added a table entry");

	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		we && state_q == ST_FIN |-> !valid_q[free_addr_q])
		else $error("insert into an occupied slot");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) != ST_IDLE)
		else $error("result beat loaded while idle");

endmodule
`default_nettype wire
